@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files of the ID allocator (included by the sequencer).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg)
`endif
`endif

@@ rtl/core/ssia_pkg.sv @@
// Types and constants shared by the sparse-set ID allocator.
package ssia_pkg;

  localparam int POOL_SIZE = 64;
  localparam int ID_W      = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    func_t func;
    id_t   free_id;
  } in_word_t;

  typedef struct packed {
    id_t     given_id;
    status_t status;
    cnt_t    live_count;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    id_t  rd_addr;
    logic wr_en;
    id_t  wr_addr;
    id_t  wr_data;
  } tbl_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SWAP
  } ctrl_state_t;

endpackage

@@ rtl/core/sparse_set_id_allocator_top.sv @@
// Top level of the sparse-set ID allocator: sequencer and its two tables.
//
// The block keeps a pool of 64 IDs as a sparse set. The dense table lists the
// live IDs first and the free IDs after them; the sparse table maps each ID to
// its slot in the dense table, and a live count marks the boundary. Both
// tables come out of reset as identity maps; they need no clearing pass, as
// each entry carries a written flag that reset clears, and an entry not yet
// written reads as its own index. Each request word is either an allocate,
// which hands out the ID in the dense slot at the live count, or a free,
// which swaps the freed ID with the last live one in both tables. Every
// request yields exactly one response word carrying the given ID, a status
// (ok, pool full, or ID not live) and the live count afterwards; a failed
// request changes nothing. One request is in flight at a time: an allocate
// or a rejected free passes through the lookup state, a successful free
// through lookup and swap, because each table has a single write port and
// a swap writes two entries in each. The lookup reads are registered. The
// response sits in an output register, so a finished word may wait for the
// consumer while the next request is taken in; the block only stalls when a
// second result is ready before the first has left.
module sparse_set_id_allocator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ssia_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ssia_pkg::out_word_t rsp
);
  import ssia_pkg::*;

  tbl_req_t dense_req;
  tbl_req_t sparse_req;
  id_t      dense_rd;
  id_t      sparse_rd;

  // Sequencer: owns the live count and the response register.
  ssia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .dense_req (dense_req),
    .sparse_req(sparse_req),
    .dense_rd  (dense_rd),
    .sparse_rd (sparse_rd)
  );

  // Dense table: slot to ID.
  ssia_table u_dense (
    .clk    (clk),
    .rst    (rst),
    .req    (dense_req),
    .rd_data(dense_rd)
  );

  // Sparse table: ID to slot.
  ssia_table u_sparse (
    .clk    (clk),
    .rst    (rst),
    .req    (sparse_req),
    .rd_data(sparse_rd)
  );

endmodule

@@ rtl/core/ssia_table.sv @@
// One table of the sparse set: synchronous memory whose unwritten entries read as their index.
module ssia_table (
  input  logic              clk,
  input  logic              rst,
  input  ssia_pkg::tbl_req_t req,
  output ssia_pkg::id_t      rd_data
);
  import ssia_pkg::*;

  id_t                  mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] written;
  id_t                  raw_q;
  id_t                  addr_q;
  logic                 hit_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      raw_q  <= mem[req.rd_addr];
      addr_q <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_q <= written[req.rd_addr];
      end
    end
  end

  // An entry never written since reset still holds its identity value.
  assign rd_data = hit_q ? raw_q : addr_q;

endmodule

@@ rtl/core/ssia_ctrl.sv @@
// Sequencer of the allocator: live count, table accesses and the result register.
`include "assert_macros.svh"

module ssia_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ssia_pkg::in_word_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ssia_pkg::out_word_t rsp,
  output ssia_pkg::tbl_req_t  dense_req,
  output ssia_pkg::tbl_req_t  sparse_req,
  input  ssia_pkg::id_t       dense_rd,
  input  ssia_pkg::id_t       sparse_rd
);
  import ssia_pkg::*;

  ctrl_state_t state, state_next;
  cnt_t        live, live_next;
  func_t       func_q;
  id_t         id_q;
  cnt_t        live_dec;
  id_t         last_slot;
  logic        full;
  logic        hit_live;
  logic        out_free;
  logic        fin;
  out_word_t   fin_word;

  assign live_dec  = live - cnt_t'(1);
  assign last_slot = live_dec[ID_W-1:0];
  assign full      = (live == cnt_t'(POOL_SIZE));
  assign hit_live  = (cnt_t'(sparse_rd) < live);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    live_next  = live;
    req_ready  = 1'b0;
    dense_req  = '0;
    sparse_req = '0;
    fin        = 1'b0;
    fin_word   = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          dense_req.rd_en   = 1'b1;
          dense_req.rd_addr = (req.func == FUNC_FREE) ? last_slot : live[ID_W-1:0];
          sparse_req.rd_en   = 1'b1;
          sparse_req.rd_addr = req.free_id;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (func_q == FUNC_ALLOC) begin
          fin_word.given_id   = full ? '0 : dense_rd;
          fin_word.status     = full ? ST_FULL : ST_OK;
          fin_word.live_count = full ? live : live + cnt_t'(1);
          if (out_free) begin
            fin        = 1'b1;
            live_next  = fin_word.live_count;
            state_next = S_IDLE;
          end
        end else if (!hit_live) begin
          fin_word.status     = ST_NOT_LIVE;
          fin_word.live_count = live;
          if (out_free) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          // Move the last live ID into the freed ID's slot.
          dense_req.wr_en    = 1'b1;
          dense_req.wr_addr  = sparse_rd;
          dense_req.wr_data  = dense_rd;
          sparse_req.wr_en   = 1'b1;
          sparse_req.wr_addr = dense_rd;
          sparse_req.wr_data = sparse_rd;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        fin_word.status     = ST_OK;
        fin_word.live_count = live_dec;
        if (out_free) begin
          // Park the freed ID just past the live part.
          dense_req.wr_en    = 1'b1;
          dense_req.wr_addr  = last_slot;
          dense_req.wr_data  = id_q;
          sparse_req.wr_en   = 1'b1;
          sparse_req.wr_addr = id_q;
          sparse_req.wr_data = last_slot;
          live_next  = live_dec;
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      live  <= live_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp <= fin_word;
    end
    if (req_valid && req_ready) begin
      func_q <= req.func;
      id_q   <= req.free_id;
    end
  end

  `ASSERT_ALWAYS(a_live_bound, clk, rst, live <= cnt_t'(POOL_SIZE), "live count beyond pool size")
  `ASSERT_IMPLY(a_rsp_count, clk, rst, rsp_valid, rsp.live_count == live, "posted count is stale")
  `ASSERT_IMPLY(a_idle_no_write, clk, rst, state == S_IDLE, !dense_req.wr_en && !sparse_req.wr_en, "table write while idle")

endmodule

@@ bench/id_pool_sb_pkg.sv @@
// Shadow of the ID pool that predicts and checks every response word.
`timescale 1ns / 100ps
package id_pool_sb_pkg;
  import ssia_pkg::*;

  class id_pool_shadow;
    id_t       dense_ids[POOL_SIZE];
    id_t       id_slots[POOL_SIZE];
    cnt_t      live;
    out_word_t expected_rsp[$];
    int unsigned failures;
    int unsigned granted;
    int unsigned refused_full;
    int unsigned released;
    int unsigned refused_not_live;
    int unsigned peak_live;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) begin
        dense_ids[i] = id_t'(i);
        id_slots[i]  = id_t'(i);
      end
      live = '0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Any ID that is live right now, or a random one if the pool is empty.
    function id_t pick_live_id();
      if (live == 0) return id_t'($urandom_range(POOL_SIZE - 1));
      return dense_ids[$urandom_range(int'(live) - 1)];
    endfunction

    // Applies one accepted request to the shadow pool and queues its response.
    function void note_request(in_word_t w);
      out_word_t exp;
      id_t       slot;
      id_t       last_slot;
      id_t       last_id;
      exp        = '0;
      exp.status = ST_OK;
      if (w.func == FUNC_ALLOC) begin
        if (live == cnt_t'(POOL_SIZE)) begin
          exp.status = ST_FULL;
          refused_full++;
        end else begin
          slot = id_t'(live);
          exp.given_id = dense_ids[slot];
          id_slots[dense_ids[slot]] = slot;
          live = live + 1'b1;
          granted++;
        end
      end else begin
        slot = id_slots[w.free_id];
        if (int'(w.free_id) >= POOL_SIZE || cnt_t'(slot) >= live) begin
          exp.status = ST_NOT_LIVE;
          refused_not_live++;
        end else begin
          last_slot            = id_t'(live - 1'b1);
          last_id              = dense_ids[last_slot];
          dense_ids[slot]      = last_id;
          dense_ids[last_slot] = w.free_id;
          id_slots[last_id]    = slot;
          id_slots[w.free_id]  = last_slot;
          live                 = live - 1'b1;
          released++;
        end
      end
      if (live > peak_live) peak_live = live;
      exp.live_count = live;
      expected_rsp.push_back(exp);
    endfunction

    function void check_response(out_word_t got);
      out_word_t exp;
      if (expected_rsp.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected response word: given_id %0d status %0d live_count %0d",
                   got.given_id, got.status, got.live_count);
        return;
      end
      exp = expected_rsp.pop_front();
      if (got.given_id !== exp.given_id || got.status !== exp.status ||
          got.live_count !== exp.live_count) begin
        failures++;
        if (failures <= 10)
          $display("response mismatch: expected id %0d status %0d count %0d, got id %0d status %0d count %0d",
                   exp.given_id, exp.status, exp.live_count,
                   got.given_id, got.status, got.live_count);
      end
    endfunction
  endclass

endpackage

@@ bench/tb.sv @@
// Testbench top level for the sparse-set ID allocator.
`timescale 1ns / 100ps
module tb;
  import ssia_pkg::*;
  import id_pool_sb_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_WORDS   = 600;
  localparam int IDLE_PCT       = 29;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 200000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      rsp_ready = 1'b0;
  in_word_t  req       = '0;
  logic      req_ready;
  logic      rsp_valid;
  out_word_t rsp;

  id_pool_shadow pool = new();

  // Set by the request side: no_idle suppresses random gaps on both sides,
  // hold_rsp asks the response side for one long hold-off.
  bit no_idle  = 1'b0;
  bit hold_rsp = 1'b0;
  int hold_left = 0;

  always #HALF_PERIOD clk = ~clk;

  sparse_set_id_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Both handshakes are observed at the rising edge. The request is noted
  // before the response is checked, so the order holds even if a response
  // word were to leave in the same cycle as its request arrives.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) pool.note_request(req);
      if (rsp_valid && rsp_ready) pool.check_response(rsp);
    end
  end

  // Response side. It idles at random, except during the quiet stretch, and
  // once holds ready low for a long run of cycles that it counts itself, so
  // that the output register and the request path back up behind it.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        rsp_ready = 1'b0;
        hold_left--;
      end else if (hold_rsp) begin
        hold_rsp  = 1'b0;
        hold_left = HOLD_CYCLES;
        rsp_ready = 1'b0;
      end else begin
        rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request word from a falling edge and returns at the falling
  // edge after it has been taken. Valid is left high on return; the next call
  // either replaces the payload at once or lowers valid for a gap, so a word
  // is never offered twice.
  task automatic send_word(input func_t f, input id_t id);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid    = 1'b1;
    req.func     = f;
    req.free_id  = id;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One random request. Most frees name an ID that is live at that moment,
  // which is what exercises the swap; the rest name any ID at all.
  task automatic send_random(input int alloc_pct);
    func_t f;
    id_t   id;
    id = id_t'($urandom_range(POOL_SIZE - 1));
    if ($urandom_range(99) < alloc_pct) begin
      f = FUNC_ALLOC;
    end else begin
      f = FUNC_FREE;
      if ($urandom_range(99) < 80) id = pool.pick_live_id();
    end
    send_word(f, id);
  endtask

  initial begin
    int alloc_pct;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: frees on an empty pool at both ends of the ID range,
    // a short run of allocates, a free from the middle of the live part, a
    // repeated free of the same ID, frees of a middle and the first live
    // slot, and an allocate whose ignored ID field has every bit set.
    send_word(FUNC_FREE,  6'd0);
    send_word(FUNC_FREE,  6'd63);
    send_word(FUNC_ALLOC, 6'd0);
    send_word(FUNC_ALLOC, 6'd0);
    send_word(FUNC_ALLOC, 6'd0);
    send_word(FUNC_ALLOC, 6'd0);
    send_word(FUNC_FREE,  6'd1);
    send_word(FUNC_FREE,  6'd1);
    send_word(FUNC_FREE,  6'd3);
    send_word(FUNC_ALLOC, 6'd63);
    send_word(FUNC_FREE,  6'd2);
    send_word(FUNC_FREE,  6'd0);
    send_word(FUNC_ALLOC, 6'd42);
    send_word(FUNC_ALLOC, 6'd21);
    send_word(FUNC_FREE,  6'd63);
    send_word(FUNC_FREE,  6'd42);
    send_word(FUNC_FREE,  6'd21);
    send_word(FUNC_ALLOC, 6'd0);

    // Random words in phases: an allocate-heavy phase that fills the pool and
    // keeps knocking on it when full, a free-heavy phase that drains it past
    // empty, a balanced phase, and then a second fill and drain.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n < 150)      alloc_pct = 85;
      else if (n < 300) alloc_pct = 15;
      else if (n < 450) alloc_pct = 50;
      else if (n < 525) alloc_pct = 90;
      else              alloc_pct = 10;

      if (n == 100) hold_rsp = 1'b1;
      if (n == 250) begin
        // Let the block run dry before carrying on.
        req_valid = 1'b0;
        while (pool.pending() != 0) @(posedge clk);
        @(negedge clk);
      end
      no_idle = (n >= 320 && n < 420);
      send_random(alloc_pct);
    end
    req_valid = 1'b0;
    no_idle   = 1'b0;

    // Wait for the last response, then a few more cycles to catch any
    // stray word.
    while (pool.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d allocates granted and %0d refused as full, peak live count %0d.",
             pool.granted, pool.refused_full, pool.peak_live);
    $display("Covered %0d frees with swap and %0d refused as not live; %0d failures.",
             pool.released, pool.refused_not_live, pool.failures);
    if (pool.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("simulation failed");
    $finish;
  end

endmodule
